@@ rtl/ps2_mouse_packet_cursor_core_defines.svh @@
// ----------------------------------------------------------------------------
// ps2_mouse_packet_cursor_core_defines.svh
// Assertion macros shared by the PS/2 mouse packet cursor RTL.
// ----------------------------------------------------------------------------
`ifndef PS2_MOUSE_PACKET_CURSOR_CORE_DEFINES_SVH
`define PS2_MOUSE_PACKET_CURSOR_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PS2MPC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PS2MPC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/ps2mpc_pkg.sv @@
// ----------------------------------------------------------------------------
// ps2mpc_pkg
// Types and constants for the PS/2 mouse packet cursor block.
// ----------------------------------------------------------------------------
`default_nettype none

package ps2mpc_pkg;

	// Configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 12;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_X = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_Y = 2'd1;

	// Reset values
	localparam int MAX_X_RESET = 1023;
	localparam int MAX_Y_RESET = 767;
	localparam int POS_RESET   = 100;

	// Header byte layout
	localparam int HDR_XSIGN_BIT = 4;
	localparam int HDR_YSIGN_BIT = 5;
	localparam int BTN_W         = 3;

	// Movement delta: sign flag plus byte
	localparam int DELTA_W = 9;

	// Position of the next byte within a packet
	typedef enum logic [1:0] {
		IDX_HEADER = 2'd0,
		IDX_XMOVE  = 2'd1,
		IDX_YMOVE  = 2'd2
	} pkt_idx_t;

endpackage

`default_nettype wire

@@ rtl/ps2mpc_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// ps2mpc_cfg_regs
// Clamp limit registers written through the plain configuration port.
// ----------------------------------------------------------------------------
`default_nettype none

module ps2mpc_cfg_regs #(
	parameter int COORD_BITS = 12
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_wr_en,
	input  wire logic [ps2mpc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [ps2mpc_pkg::CFG_DATA_W-1:0]    cfg_data,
	output logic      [COORD_BITS-1:0]                max_x,
	output logic      [COORD_BITS-1:0]                max_y
);

	logic [COORD_BITS-1:0] max_x_q;
	logic [COORD_BITS-1:0] max_y_q;
	logic [COORD_BITS-1:0] wr_val;

	// Register value is the data fitted to the coordinate width
	assign wr_val = COORD_BITS'(cfg_data);

	// Register write decode; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_x_q <= COORD_BITS'(ps2mpc_pkg::MAX_X_RESET);
			max_y_q <= COORD_BITS'(ps2mpc_pkg::MAX_Y_RESET);
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				ps2mpc_pkg::REG_MAX_X: max_x_q <= wr_val;
				ps2mpc_pkg::REG_MAX_Y: max_y_q <= wr_val;
				default: ;
			endcase
		end
	end

	assign max_x = max_x_q;
	assign max_y = max_y_q;

endmodule

`default_nettype wire

@@ rtl/ps2mpc_decode.sv @@
// ----------------------------------------------------------------------------
// ps2mpc_decode
// Input register, packet gathering and clamped cursor update.
// ----------------------------------------------------------------------------
`default_nettype none
`include "ps2_mouse_packet_cursor_core_defines.svh"

module ps2mpc_decode #(
	parameter int COORD_BITS = 12
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             rx_valid,
	output logic                                  rx_ready,
	input  wire logic [7:0]                       rx_byte,
	input  wire logic [COORD_BITS-1:0]            max_x,
	input  wire logic [COORD_BITS-1:0]            max_y,
	input  wire logic                             res_room,
	output logic                                  res_load,
	output logic      [COORD_BITS-1:0]            res_x,
	output logic      [COORD_BITS-1:0]            res_y,
	output logic      [ps2mpc_pkg::BTN_W-1:0]     res_btn
);

	localparam int SUM_W = COORD_BITS + 2;

	logic                     valid_s1;
	logic [7:0]               byte_s1;
	ps2mpc_pkg::pkt_idx_t     idx_q;
	ps2mpc_pkg::pkt_idx_t     idx_d;
	logic [7:0]               hdr_q;
	logic [7:0]               xmove_q;
	logic [COORD_BITS-1:0]    pos_x_q;
	logic [COORD_BITS-1:0]    pos_y_q;
	logic                     last_byte;
	logic                     adv;
	logic                     take_hdr;
	logic                     take_x;
	logic signed [ps2mpc_pkg::DELTA_W-1:0] dx;
	logic signed [ps2mpc_pkg::DELTA_W-1:0] dy;
	logic signed [SUM_W-1:0]  sum_x;
	logic signed [SUM_W-1:0]  sum_y;
	logic [COORD_BITS-1:0]    new_x;
	logic [COORD_BITS-1:0]    new_y;

	// Handshake: the input stage advances unless a finished packet has no room
	assign last_byte = (idx_q == ps2mpc_pkg::IDX_YMOVE);
	assign adv       = valid_s1 && (!last_byte || res_room);
	assign rx_ready  = !valid_s1 || adv;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx_ready) begin
			valid_s1 <= rx_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_valid && rx_ready) begin
			byte_s1 <= rx_byte;
		end
	end

	// Next byte position
	always_comb begin
		unique case (idx_q)
			ps2mpc_pkg::IDX_XMOVE: idx_d = ps2mpc_pkg::IDX_YMOVE;
			ps2mpc_pkg::IDX_YMOVE: idx_d = ps2mpc_pkg::IDX_HEADER;
			default:               idx_d = ps2mpc_pkg::IDX_XMOVE;
		endcase
	end

	// Which byte the current one is; an unused code counts as a header
	always_comb begin
		take_hdr = 1'b0;
		take_x   = 1'b0;
		unique case (idx_q)
			ps2mpc_pkg::IDX_XMOVE: take_x   = 1'b1;
			ps2mpc_pkg::IDX_YMOVE: ;
			default:               take_hdr = 1'b1;
		endcase
	end

	// 9-bit deltas, y subtracted since screen y points down
	assign dx    = {hdr_q[ps2mpc_pkg::HDR_XSIGN_BIT], xmove_q};
	assign dy    = {hdr_q[ps2mpc_pkg::HDR_YSIGN_BIT], byte_s1};
	assign sum_x = $signed({2'b00, pos_x_q}) + SUM_W'(dx);
	assign sum_y = $signed({2'b00, pos_y_q}) - SUM_W'(dy);

	// Saturate to [0, max]
	always_comb begin
		if (sum_x[SUM_W-1]) begin
			new_x = '0;
		end else if (sum_x[SUM_W-2:0] > {1'b0, max_x}) begin
			new_x = max_x;
		end else begin
			new_x = sum_x[COORD_BITS-1:0];
		end
		if (sum_y[SUM_W-1]) begin
			new_y = '0;
		end else if (sum_y[SUM_W-2:0] > {1'b0, max_y}) begin
			new_y = max_y;
		end else begin
			new_y = sum_y[COORD_BITS-1:0];
		end
	end

	// Packet state and cursor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= ps2mpc_pkg::IDX_HEADER;
			hdr_q   <= '0;
			xmove_q <= '0;
			pos_x_q <= COORD_BITS'(ps2mpc_pkg::POS_RESET);
			pos_y_q <= COORD_BITS'(ps2mpc_pkg::POS_RESET);
		end else if (adv) begin
			idx_q <= idx_d;
			if (take_hdr) begin
				hdr_q <= byte_s1;
			end
			if (take_x) begin
				xmove_q <= byte_s1;
			end
			if (last_byte) begin
				pos_x_q <= new_x;
				pos_y_q <= new_y;
			end
		end
	end

	// Result toward the output register
	assign res_load = adv && last_byte;
	assign res_x    = new_x;
	assign res_y    = new_y;
	assign res_btn  = hdr_q[ps2mpc_pkg::BTN_W-1:0];

	`PS2MPC_ASSERT_NXT(a_hdr_then_x, clk, arst_n, adv && (idx_q == ps2mpc_pkg::IDX_HEADER),
		idx_q == ps2mpc_pkg::IDX_XMOVE, "header byte not followed by x position")
	`PS2MPC_ASSERT_NXT(a_pkt_wraps, clk, arst_n, adv && (idx_q == ps2mpc_pkg::IDX_YMOVE),
		idx_q == ps2mpc_pkg::IDX_HEADER, "packet end did not return to header")
	`PS2MPC_ASSERT_NXT(a_s1_holds, clk, arst_n, valid_s1 && !adv,
		valid_s1 && (idx_q == ps2mpc_pkg::IDX_YMOVE), "stalled byte lost")

endmodule

`default_nettype wire

@@ rtl/ps2mpc_out_reg.sv @@
// ----------------------------------------------------------------------------
// ps2mpc_out_reg
// Result register holding one cursor report until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module ps2mpc_out_reg #(
	parameter int COORD_BITS = 12
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             load,
	input  wire logic [COORD_BITS-1:0]            in_x,
	input  wire logic [COORD_BITS-1:0]            in_y,
	input  wire logic [ps2mpc_pkg::BTN_W-1:0]     in_btn,
	output logic                                  room,
	output logic                                  cursor_valid,
	input  wire logic                             cursor_ready,
	output logic      [COORD_BITS-1:0]            cursor_x,
	output logic      [COORD_BITS-1:0]            cursor_y,
	output logic      [ps2mpc_pkg::BTN_W-1:0]     button_bits
);

	logic                          valid_q;
	logic [COORD_BITS-1:0]         x_q;
	logic [COORD_BITS-1:0]         y_q;
	logic [ps2mpc_pkg::BTN_W-1:0]  btn_q;

	// Free now, or freed by the transaction at this edge
	assign room = !valid_q || cursor_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (cursor_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			x_q   <= in_x;
			y_q   <= in_y;
			btn_q <= in_btn;
		end
	end

	assign cursor_valid = valid_q;
	assign cursor_x     = x_q;
	assign cursor_y     = y_q;
	assign button_bits  = btn_q;

endmodule

`default_nettype wire

@@ rtl/ps2_mouse_packet_cursor_core.sv @@
// ----------------------------------------------------------------------------
// ps2_mouse_packet_cursor_core
// PS/2 mouse three-byte packet decoder with a clamped cursor.
// ----------------------------------------------------------------------------
// Bytes enter on rx_* one per transaction and are grouped by position into
// header, x movement and y movement. Each third byte yields one report on
// cursor_*: x plus dx and y minus dy (9-bit deltas with signs from header
// bits 4 and 5), each clamped to [0, max], and header bits 2..0 as buttons.
// One byte is taken per cycle unless a third byte waits for the result
// register. A byte sits in an input register, then is applied to the cursor
// as its report loads into the result register, so new bytes keep flowing
// while a report waits. The user writes limits max_x (index 0) and max_y
// (index 1) through cfg_* only while the block is idle; the block does not enforce it.
`default_nettype none

module ps2_mouse_packet_cursor_core #(
	parameter int COORD_BITS = 12
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 rx_valid,
	output logic                                      rx_ready,
	input  wire logic [7:0]                           rx_byte,
	output logic                                      cursor_valid,
	input  wire logic                                 cursor_ready,
	output logic      [COORD_BITS-1:0]                cursor_x,
	output logic      [COORD_BITS-1:0]                cursor_y,
	output logic      [ps2mpc_pkg::BTN_W-1:0]         button_bits,
	input  wire logic                                 cfg_wr_en,
	input  wire logic [ps2mpc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [ps2mpc_pkg::CFG_DATA_W-1:0]    cfg_data
);

	logic [COORD_BITS-1:0]         max_x;
	logic [COORD_BITS-1:0]         max_y;
	logic                          res_room;
	logic                          res_load;
	logic [COORD_BITS-1:0]         res_x;
	logic [COORD_BITS-1:0]         res_y;
	logic [ps2mpc_pkg::BTN_W-1:0]  res_btn;

	// Clamp limits
	ps2mpc_cfg_regs #(
		.COORD_BITS (COORD_BITS)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.max_x     (max_x),
		.max_y     (max_y)
	);

	// Packet gathering and cursor update
	ps2mpc_decode #(
		.COORD_BITS (COORD_BITS)
	) u_decode (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx_valid (rx_valid),
		.rx_ready (rx_ready),
		.rx_byte  (rx_byte),
		.max_x    (max_x),
		.max_y    (max_y),
		.res_room (res_room),
		.res_load (res_load),
		.res_x    (res_x),
		.res_y    (res_y),
		.res_btn  (res_btn)
	);

	// Report register
	ps2mpc_out_reg #(
		.COORD_BITS (COORD_BITS)
	) u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (res_load),
		.in_x         (res_x),
		.in_y         (res_y),
		.in_btn       (res_btn),
		.room         (res_room),
		.cursor_valid (cursor_valid),
		.cursor_ready (cursor_ready),
		.cursor_x     (cursor_x),
		.cursor_y     (cursor_y),
		.button_bits  (button_bits)
	);

endmodule

`default_nettype wire

@@ test/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for ps2_mouse_packet_cursor_core. Mouse bytes are sent
// one per transaction: a short directed set first, then random phases with a
// fresh pair of cursor limits each. A predictor tracks packet position,
// cursor and limits, and queues the report that each third byte should
// produce. Reports from the block are checked field by field, in order.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int COORD_BITS      = 12;
	localparam int CLK_HALF        = 10;
	localparam int IDLE_PCT        = 10;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int DRAIN_CYCLES    = 6;
	localparam int STUCK_LIMIT     = 2000;
	localparam int RAND_PHASES     = 8;
	localparam int PHASE_BYTES     = 200;

	// Indexes that map to no register; writes to them must be ignored
	localparam logic [ps2mpc_pkg::CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
	localparam logic [ps2mpc_pkg::CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

	typedef logic [COORD_BITS-1:0] coord_t;

	typedef struct {
		coord_t                       x;
		coord_t                       y;
		logic [ps2mpc_pkg::BTN_W-1:0] btn;
	} cursor_rpt_t;

	logic                              clk          = 1'b0;
	logic                              arst_n       = 1'b0;
	logic                              rx_valid     = 1'b0;
	logic                              rx_ready;
	logic [7:0]                        rx_byte      = '0;
	logic                              cursor_valid;
	logic                              cursor_ready = 1'b0;
	coord_t                            cursor_x;
	coord_t                            cursor_y;
	logic [ps2mpc_pkg::BTN_W-1:0]      button_bits;
	logic                              cfg_wr_en    = 1'b0;
	logic [ps2mpc_pkg::CFG_IDX_W-1:0]  cfg_index    = '0;
	logic [ps2mpc_pkg::CFG_DATA_W-1:0] cfg_data     = '0;

	// Stimulus and expected reports
	logic [7:0]  rx_byte_q[$];
	cursor_rpt_t cursor_expect_q[$];

	// Traffic shaping, set by the sequence
	bit          quiet_mode   = 1'b0;
	int unsigned hold_req_seq = 0;

	int mismatch_cnt = 0;

	// Predictor state
	ps2mpc_pkg::pkt_idx_t pkt_slot  = ps2mpc_pkg::IDX_HEADER;
	logic [7:0]           hdr_byte  = '0;
	logic [7:0]           xmov_byte = '0;
	coord_t               cur_x     = coord_t'(ps2mpc_pkg::POS_RESET);
	coord_t               cur_y     = coord_t'(ps2mpc_pkg::POS_RESET);
	coord_t               lim_x     = coord_t'(ps2mpc_pkg::MAX_X_RESET);
	coord_t               lim_y     = coord_t'(ps2mpc_pkg::MAX_Y_RESET);

	ps2_mouse_packet_cursor_core #(
		.COORD_BITS(COORD_BITS)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.rx_valid    (rx_valid),
		.rx_ready    (rx_ready),
		.rx_byte     (rx_byte),
		.cursor_valid(cursor_valid),
		.cursor_ready(cursor_ready),
		.cursor_x    (cursor_x),
		.cursor_y    (cursor_y),
		.button_bits (button_bits),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always #CLK_HALF clk = ~clk;

	function automatic coord_t clamp_to_limit(int v, coord_t lim);
		if (v < 0)
			return '0;
		if (v > int'(lim))
			return lim;
		return coord_t'(v);
	endfunction

	// Place one byte by position; the third byte of a packet moves the cursor
	task automatic decode_rx_byte(input logic [7:0] b);
		logic signed [ps2mpc_pkg::DELTA_W-1:0] dx;
		logic signed [ps2mpc_pkg::DELTA_W-1:0] dy;
		cursor_rpt_t                           rpt;
		case (pkt_slot)
			ps2mpc_pkg::IDX_XMOVE: begin
				xmov_byte = b;
				pkt_slot  = ps2mpc_pkg::IDX_YMOVE;
			end
			ps2mpc_pkg::IDX_YMOVE: begin
				pkt_slot = ps2mpc_pkg::IDX_HEADER;
				dx       = {hdr_byte[ps2mpc_pkg::HDR_XSIGN_BIT], xmov_byte};
				dy       = {hdr_byte[ps2mpc_pkg::HDR_YSIGN_BIT], b};
				cur_x    = clamp_to_limit(int'(cur_x) + int'(dx), lim_x);
				cur_y    = clamp_to_limit(int'(cur_y) - int'(dy), lim_y);
				rpt.x    = cur_x;
				rpt.y    = cur_y;
				rpt.btn  = hdr_byte[ps2mpc_pkg::BTN_W-1:0];
				cursor_expect_q.push_back(rpt);
			end
			default: begin
				hdr_byte = b;
				pkt_slot = ps2mpc_pkg::IDX_XMOVE;
			end
		endcase
	endtask

	// Byte driver; also tracks register writes and accepted bytes
	always @(posedge clk) begin
		if (cfg_wr_en) begin
			case (cfg_index)
				ps2mpc_pkg::REG_MAX_X: lim_x = cfg_data;
				ps2mpc_pkg::REG_MAX_Y: lim_y = cfg_data;
				default: ;
			endcase
		end
		if (!arst_n) begin
			rx_valid <= 1'b0;
		end else begin
			if (rx_valid && rx_ready)
				decode_rx_byte(rx_byte);
			if (!rx_valid || rx_ready) begin
				if (rx_byte_q.size() != 0 &&
				    (quiet_mode || $urandom_range(99) >= IDLE_PCT)) begin
					rx_valid <= 1'b1;
					rx_byte  <= rx_byte_q.pop_front();
				end else begin
					rx_valid <= 1'b0;
				end
			end
		end
	end

	// Report monitor and ready control
	int unsigned hold_seen = 0;
	int unsigned hold_left = 0;

	always @(posedge clk) begin
		cursor_rpt_t exp_rpt;
		if (cursor_valid && cursor_ready) begin
			if (cursor_expect_q.size() == 0) begin
				$error("unexpected report: x %0d y %0d buttons %0d",
				       cursor_x, cursor_y, button_bits);
				mismatch_cnt++;
			end else begin
				exp_rpt = cursor_expect_q.pop_front();
				if (cursor_x !== exp_rpt.x) begin
					$error("cursor_x: expected %0d, got %0d", exp_rpt.x, cursor_x);
					mismatch_cnt++;
				end
				if (cursor_y !== exp_rpt.y) begin
					$error("cursor_y: expected %0d, got %0d", exp_rpt.y, cursor_y);
					mismatch_cnt++;
				end
				if (button_bits !== exp_rpt.btn) begin
					$error("button_bits: expected %0d, got %0d", exp_rpt.btn,
					       button_bits);
					mismatch_cnt++;
				end
			end
		end
		if (hold_seen != hold_req_seq) begin
			hold_seen = hold_req_seq;
			hold_left = HOLD_OFF_CYCLES;
		end
		if (!arst_n) begin
			cursor_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left--;
			cursor_ready <= 1'b0;
		end else begin
			cursor_ready <= quiet_mode || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// Watchdog: cycles in a row with no transaction and no register write
	int unsigned stuck_cnt = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((rx_valid && rx_ready) || (cursor_valid && cursor_ready) || cfg_wr_en)
				stuck_cnt = 0;
			else
				stuck_cnt++;
			if (stuck_cnt >= STUCK_LIMIT) begin
				$display("** ps2_mouse_packet_cursor_core: FAILED **");
				$finish;
			end
		end
	end

	task automatic send_packet(input logic [7:0] h, input logic [7:0] x,
	                           input logic [7:0] y);
		rx_byte_q.push_back(h);
		rx_byte_q.push_back(x);
		rx_byte_q.push_back(y);
	endtask

	// Wait until every byte is taken and every report has come, then let
	// a trailing header or x byte settle inside the block
	task automatic wait_drained();
		do
			@(posedge clk);
		while (rx_byte_q.size() != 0 || rx_valid || cursor_expect_q.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// One write per call, on successive edges; caller lowers the enable
	task automatic cfg_write(input logic [ps2mpc_pkg::CFG_IDX_W-1:0] idx,
	                         input logic [ps2mpc_pkg::CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
	endtask

	task automatic cfg_done();
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	function automatic logic [ps2mpc_pkg::CFG_DATA_W-1:0] pick_limit();
		case ($urandom_range(4))
			0:       return '0;
			1:       return '1;
			2:       return ps2mpc_pkg::CFG_DATA_W'($urandom_range(31));
			default: return ps2mpc_pkg::CFG_DATA_W'($urandom_range(4095));
		endcase
	endfunction

	function automatic logic [7:0] pick_rx_byte();
		if ($urandom_range(3) != 0)
			return 8'($urandom);
		// Small moves either way keep the cursor wandering off the walls
		if ($urandom_range(1) != 0)
			return 8'($urandom_range(15));
		return 8'hF0 | 8'($urandom_range(15));
	endfunction

	initial begin
		logic [ps2mpc_pkg::CFG_DATA_W-1:0] new_max_x;
		logic [ps2mpc_pkg::CFG_DATA_W-1:0] new_max_y;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: reset limits, sign extremes, ignored header flags
		send_packet(8'h00, 8'h00, 8'h00);   // no motion from the reset position
		send_packet(8'h17, 8'h00, 8'hFF);   // dx -256, dy +255: both clamp to 0
		send_packet(8'hE9, 8'hFF, 8'h00);   // overflow and sync bits set, dy -256
		send_packet(8'h3F, 8'hFF, 8'hFF);   // both deltas -1, all buttons
		send_packet(8'h24, 8'hFF, 8'h00);
		send_packet(8'h24, 8'hFF, 8'h00);
		send_packet(8'h24, 8'hFF, 8'h00);   // y stays at its upper limit
		send_packet(8'h22, 8'hFF, 8'h00);   // x reaches its upper limit
		wait_drained();

		// Lower both limits below the cursor; next packet pulls it back
		cfg_write(ps2mpc_pkg::REG_MAX_X, 12'd10);
		cfg_write(ps2mpc_pkg::REG_MAX_Y, 12'd5);
		cfg_done();
		send_packet(8'h00, 8'h00, 8'h00);
		wait_drained();

		// Writes to unmapped indexes must leave the limits alone
		cfg_write(REG_SPARE_2, '1);
		cfg_write(REG_SPARE_3, '0);
		cfg_done();
		send_packet(8'h01, 8'h7F, 8'h80);
		wait_drained();

		// Random phases; phase 0 runs without idling, phase 1 starts with a
		// long receiver hold-off so the block backs up into the sender
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			case (ph)
				0: begin
					new_max_x = '1;
					new_max_y = '0;
				end
				1: begin
					new_max_x = '0;
					new_max_y = '1;
				end
				default: begin
					new_max_x = pick_limit();
					new_max_y = pick_limit();
				end
			endcase
			cfg_write(ps2mpc_pkg::REG_MAX_X, new_max_x);
			cfg_write(ps2mpc_pkg::REG_MAX_Y, new_max_y);
			cfg_write(ph % 2 ? REG_SPARE_3 : REG_SPARE_2,
			          ps2mpc_pkg::CFG_DATA_W'($urandom));
			@(posedge clk);
			cfg_wr_en  <= 1'b0;
			quiet_mode <= (ph == 0);
			if (ph == 1)
				hold_req_seq <= hold_req_seq + 1;
			for (int i = 0; i < PHASE_BYTES; i++)
				rx_byte_q.push_back(pick_rx_byte());
			wait_drained();
		end

		if (mismatch_cnt == 0)
			$display("** ps2_mouse_packet_cursor_core: PASSED **");
		else
			$display("** ps2_mouse_packet_cursor_core: FAILED **");
		$finish;
	end

endmodule
